[hdl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg - shared types and constants of the circle rasteriser
// Coordinate width, register indexes, reset values and the job record
// passed from the command front end to the point generator.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Width of coordinates, steps and the decision term
    localparam int COORD_BITS  = 16;
    localparam int RADIUS_BITS = 13;
    localparam int COLOR_BITS  = 16;
    localparam int SCREEN_BITS = 9;

    // Job queue depth between the front end and the point generator
    localparam int JQ_DEPTH    = 4;
    localparam int JQ_AW       = $clog2(JQ_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = SCREEN_BITS'(240);
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = SCREEN_BITS'(320);

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Number of mirrored points per iteration
    localparam int POINTS     = 8;
    localparam int POINT_BITS = $clog2(POINTS);

    // One unit of work for the point generator
    typedef struct packed {
        logic                         fin;    // emit a single finished result
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic        [COLOR_BITS-1:0] color;
    } t_job;

endpackage

[hdl/mcr_front.sv]
// ----------------------------------------------------------------------------
// mcr_front - command front end
// Takes start and tick commands, holds the midpoint iteration state and
// posts one job per tick to the job queue.
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_command,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic signed [RADIUS_BITS-1:0] i_radius,
    input  logic        [COLOR_BITS-1:0]  i_color,
    output logic                          o_q_push,
    output t_job                          o_q_job
);

    logic                         r_active, n_active;
    logic signed [COORD_BITS-1:0] r_cx, n_cx;
    logic signed [COORD_BITS-1:0] r_cy, n_cy;
    logic signed [COORD_BITS-1:0] r_sx, n_sx;
    logic signed [COORD_BITS-1:0] r_sy, n_sy;
    logic signed [COORD_BITS-1:0] r_dec, n_dec;
    logic        [COLOR_BITS-1:0] r_color, n_color;

    logic                         done;
    logic signed [COORD_BITS-1:0] rad_ext;

    assign rad_ext = COORD_BITS'(i_radius);
    assign done    = !r_active || (r_sx < r_sy);

    // Classify the item and advance the iteration
    always_comb begin
        n_active = r_active;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_dec    = r_dec;
        n_color  = r_color;
        o_q_push = 1'b0;
        if (i_take) begin
            if (i_command == CMD_START) begin
                n_active = 1'b1;
                n_cx     = i_center_x;
                n_cy     = i_center_y;
                n_sx     = rad_ext;
                n_sy     = '0;
                n_dec    = COORD_BITS'(3) - (rad_ext <<< 1);
                n_color  = i_color;
            end else begin
                o_q_push = 1'b1;
                if (done) begin
                    n_active = 1'b0;
                end else begin
                    if (r_dec[COORD_BITS-1]) begin
                        n_dec = r_dec + (r_sy <<< 2) + COORD_BITS'(6);
                    end else begin
                        n_dec = r_dec + ((r_sy - r_sx) <<< 2) + COORD_BITS'(10);
                        n_sx  = r_sx - COORD_BITS'(1);
                    end
                    n_sy = r_sy + COORD_BITS'(1);
                end
            end
        end
    end

    // Job record for the current tick
    always_comb begin
        o_q_job.fin   = done;
        o_q_job.cx    = r_cx;
        o_q_job.cy    = r_cy;
        o_q_job.sx    = r_sx;
        o_q_job.sy    = r_sy;
        o_q_job.color = r_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_dec    <= '0;
            r_color  <= '0;
        end else begin
            r_active <= n_active;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_dec    <= n_dec;
            r_color  <= n_color;
        end
    end

endmodule

[hdl/mcr_job_fifo.sv]
// ----------------------------------------------------------------------------
// mcr_job_fifo - short job queue
// Decouples the command front end from the point generator.
// ----------------------------------------------------------------------------
module mcr_job_fifo import mcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0]  r_wp, n_wp;
    logic [JQ_AW-1:0]  r_rp, n_rp;
    logic [JQ_AW:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == (JQ_AW+1)'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Advance pointers and count
    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[hdl/mcr_back.sv]
// ----------------------------------------------------------------------------
// mcr_back - point generator
// Walks the eight mirrored points of a job, one per cycle while the output
// is free or popped, clips them to the screen and holds each until popped.
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  t_job                         i_q_job,
    output logic                         o_q_pop,
    input  logic [SCREEN_BITS-1:0]       i_width,
    input  logic [SCREEN_BITS-1:0]       i_height,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic        [COLOR_BITS-1:0] o_pixel_color,
    output logic                         o_visible,
    output logic                         o_finished,
    output logic                         o_last
);

    t_job                         r_job;
    logic                         r_busy, n_busy;
    logic [POINT_BITS-1:0]        r_k, n_k;
    logic                         r_valid, n_valid;

    logic                         adv, last_pt, load;
    logic signed [COORD_BITS-1:0] a, b, px, py;
    logic                         vis;

    assign adv     = r_busy && (!r_valid || i_pop);
    assign last_pt = r_job.fin || (r_k == POINT_BITS'(POINTS - 1));
    assign load    = (!r_busy || (adv && last_pt)) && !i_q_empty;
    assign o_q_pop = load;
    assign o_empty = !r_valid;

    // Mirror: bit 2 swaps the axes, bit 0 negates x offset, bit 1 the y offset
    always_comb begin
        a   = r_k[2] ? r_job.sy : r_job.sx;
        b   = r_k[2] ? r_job.sx : r_job.sy;
        px  = r_k[0] ? r_job.cx - a : r_job.cx + a;
        py  = r_k[1] ? r_job.cy - b : r_job.cy + b;
        vis = !px[COORD_BITS-1] && !py[COORD_BITS-1]
              && (px < COORD_BITS'(i_width)) && (py < COORD_BITS'(i_height));
    end

    // Sequence control
    always_comb begin
        n_busy  = r_busy;
        n_k     = r_k;
        n_valid = r_valid;
        if (i_pop) begin
            n_valid = 1'b0;
        end
        if (adv) begin
            n_valid = 1'b1;
            n_k     = r_k + 1'b1;
            if (last_pt) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy = 1'b1;
            n_k    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_k     <= n_k;
            r_valid <= n_valid;
        end
    end

    // Hold the job and the result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
        if (adv) begin
            o_pixel_x     <= r_job.fin ? '0 : px;
            o_pixel_y     <= r_job.fin ? '0 : py;
            o_pixel_color <= r_job.fin ? '0 : r_job.color;
            o_visible     <= r_job.fin ? 1'b0 : vis;
            o_finished    <= r_job.fin;
            o_last        <= last_pt;
        end
    end

endmodule

[hdl/midpoint_circle_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit - midpoint circle outline generator
// Start/tick commands in, clipped outline points out.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  command  | in        | push / full         | command, center, radius, color
//  result   | out       | empty / pop         | pixel x/y, colour, flags
//  config   | in        | cfg valid / ready   | register index, data
//
// A command is taken whenever the four-entry job queue has room. A tick gives
// eight points, one per cycle while the output is empty or popped; a tick on
// a finished circle gives one result. Starts give none. The output register
// refills in the cycle it is popped while a point is pending. Reset is
// synchronous: the queue empties, no circle is active, screen is 240 x 320.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit import mcr_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_command,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic signed [RADIUS_BITS-1:0] i_radius,
    input  logic        [COLOR_BITS-1:0]  i_color,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_BITS-1:0]  o_pixel_x,
    output logic signed [COORD_BITS-1:0]  o_pixel_y,
    output logic        [COLOR_BITS-1:0]  o_pixel_color,
    output logic                          o_visible,
    output logic                          o_finished,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [SCREEN_BITS-1:0]        i_cfg_data
);

    logic [SCREEN_BITS-1:0] r_width;
    logic [SCREEN_BITS-1:0] r_height;

    logic q_push, q_full, q_pop, q_empty, take;
    t_job q_wjob, q_rjob;

    assign take        = push && !q_full;
    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    // Screen size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_command  (i_command),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .o_q_push   (q_push),
        .o_q_job    (q_wjob)
    );

    mcr_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_wjob),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_rjob)
    );

    mcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_job       (q_rjob),
        .o_q_pop       (q_pop),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_visible     (o_visible),
        .o_finished    (o_finished),
        .o_last        (o_last)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the midpoint circle rasteriser
// Drives start/tick commands through the push/full queue and pops points
// through empty/pop, with random gaps on both sides. A behavioural copy of
// the circle stepper predicts every point; each popped point is compared
// field by field with the oldest prediction. A short directed table covers
// reset, wrap-around extremes, negative radius and screen edges. Random
// circles follow under several screen sizes, zero-size and full-size among
// them.
// ----------------------------------------------------------------------------
module tb_top;
    import mcr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int SHOWN_ERRORS  = 10;

    // One command as pushed into the block
    typedef struct packed {
        logic                          cmd;
        logic signed [COORD_BITS-1:0]  cx;
        logic signed [COORD_BITS-1:0]  cy;
        logic signed [RADIUS_BITS-1:0] r;
        logic        [COLOR_BITS-1:0]  color;
    } circle_cmd_t;

    // One outline point as popped from the block
    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic        [COLOR_BITS-1:0] color;
        logic                         vis;
        logic                         fin;
        logic                         last;
    } point_t;

    // Directed row: command plus whether it must close the circle
    typedef struct packed {
        circle_cmd_t c;
        logic        ends_circle;
    } step_row_t;

    localparam point_t DONE_MARK = '{px: '0, py: '0, color: '0,
                                     vis: 1'b0, fin: 1'b1, last: 1'b1};

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          push         = 1'b0;
    logic                          full;
    logic                          i_command    = CMD_TICK;
    logic signed [COORD_BITS-1:0]  i_center_x   = '0;
    logic signed [COORD_BITS-1:0]  i_center_y   = '0;
    logic signed [RADIUS_BITS-1:0] i_radius     = '0;
    logic        [COLOR_BITS-1:0]  i_color      = '0;
    logic                          empty;
    logic                          pop          = 1'b0;
    logic signed [COORD_BITS-1:0]  o_pixel_x;
    logic signed [COORD_BITS-1:0]  o_pixel_y;
    logic        [COLOR_BITS-1:0]  o_pixel_color;
    logic                          o_visible;
    logic                          o_finished;
    logic                          o_last;
    logic                          i_cfg_valid  = 1'b0;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index  = REG_SCREEN_WIDTH;
    logic [SCREEN_BITS-1:0]        i_cfg_data   = '0;

    // Stepper copy: screen registers and circle state
    logic [SCREEN_BITS-1:0]        screen_w   = WIDTH_RESET;
    logic [SCREEN_BITS-1:0]        screen_h   = HEIGHT_RESET;
    logic                          trace_on   = 1'b0;
    logic signed [COORD_BITS-1:0]  org_x      = '0;
    logic signed [COORD_BITS-1:0]  org_y      = '0;
    logic signed [COORD_BITS-1:0]  arc_x      = '0;
    logic signed [COORD_BITS-1:0]  arc_y      = '0;
    logic signed [COORD_BITS-1:0]  err_term   = '0;
    logic        [COLOR_BITS-1:0]  pen_color  = '0;
    point_t                        traced_pts [POINTS];

    point_t    pending_pixels [$];
    step_row_t opening_rows [$];

    logic calm          = 1'b0;
    int   quiet_cycles  = 0;
    int   fail_count    = 0;
    int   points_popped = 0;
    int   items_sent    = 0;
    int   ticks_sent    = 0;
    int   settings_used = 1;

    midpoint_circle_rasterizer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_color       (i_color),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_visible     (o_visible),
        .o_finished    (o_finished),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the circle stepper by one command; fill traced_pts, return count
    function automatic int plot_step(input circle_cmd_t c);
        logic signed [COORD_BITS-1:0] a;
        logic signed [COORD_BITS-1:0] b;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        int radius_i;
        if (c.cmd == CMD_START) begin
            radius_i  = int'(c.r);
            org_x     = c.cx;
            org_y     = c.cy;
            arc_x     = COORD_BITS'(radius_i);
            arc_y     = '0;
            err_term  = COORD_BITS'(3 - 2 * radius_i);
            pen_color = c.color;
            trace_on  = 1'b1;
            return 0;
        end
        // Idle or exhausted circle: a single finished marker
        if (!trace_on || arc_x < arc_y) begin
            trace_on      = 1'b0;
            traced_pts[0] = DONE_MARK;
            return 1;
        end
        // Eight mirrored points, octant pairs swap x and y
        for (int k = 0; k < POINTS; k++) begin
            a  = (k < 4) ? arc_x : arc_y;
            b  = (k < 4) ? arc_y : arc_x;
            px = ((k & 1) != 0) ? org_x - a : org_x + a;
            py = ((k & 2) != 0) ? org_y - b : org_y + b;
            traced_pts[k].px    = px;
            traced_pts[k].py    = py;
            traced_pts[k].color = pen_color;
            traced_pts[k].vis   = int'(px) >= 0 && int'(px) < int'(screen_w) &&
                                  int'(py) >= 0 && int'(py) < int'(screen_h);
            traced_pts[k].fin   = 1'b0;
            traced_pts[k].last  = (k == POINTS - 1);
        end
        // Midpoint decision update
        if (err_term < 0) begin
            err_term = COORD_BITS'(err_term + 4 * arc_y + 6);
        end else begin
            err_term = COORD_BITS'(err_term + 4 * (arc_y - arc_x) + 10);
            arc_x    = COORD_BITS'(arc_x - 1);
        end
        arc_y = COORD_BITS'(arc_y + 1);
        return POINTS;
    endfunction

    // Every field random; used for noise and as filler on ticks
    function automatic circle_cmd_t random_cmd();
        circle_cmd_t c;
        c.cmd   = 1'($urandom);
        c.cx    = COORD_BITS'($urandom);
        c.cy    = COORD_BITS'($urandom);
        c.r     = RADIUS_BITS'($urandom);
        c.color = COLOR_BITS'($urandom);
        return c;
    endfunction

    // Push one item and queue its predicted points on acceptance
    task automatic send(input circle_cmd_t c, input logic ends_circle);
        int n;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_command  <= c.cmd;
        i_center_x <= c.cx;
        i_center_y <= c.cy;
        i_radius   <= c.r;
        i_color    <= c.color;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n = plot_step(c);
        if (ends_circle) begin
            pending_pixels.push_back(DONE_MARK);
        end else begin
            for (int k = 0; k < n; k++) pending_pixels.push_back(traced_pts[k]);
        end
        items_sent++;
        if (c.cmd == CMD_TICK) ticks_sent++;
    endtask

    // Hold the sender until every predicted point has been popped
    task automatic settle();
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both screen registers back to back, valid held high between
    task automatic set_screen(input logic [SCREEN_BITS-1:0] w,
                              input logic [SCREEN_BITS-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SCREEN_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        screen_w = w;
        i_cfg_index <= REG_SCREEN_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        screen_h = h;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly whole circles near the screen, the rest raw noise
    task automatic draw_random(input int n_items);
        circle_cmd_t c;
        int          stop_at;
        int          pick;
        int          rad;
        int          n_ticks;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                pick = $urandom_range(99);
                rad  = (pick < 70) ? $urandom_range(0, 20) :
                       (pick < 90) ? $urandom_range(21, 60) : $urandom_range(61, 4095);
                n_ticks = rad * 3 / 4 + 2 + $urandom_range(0, 2);
                if (n_ticks > 30) n_ticks = $urandom_range(4, 30);
                c       = random_cmd();
                c.cmd   = CMD_START;
                c.cx    = COORD_BITS'(int'($urandom_range(0, int'(screen_w) + 40)) - 20);
                c.cy    = COORD_BITS'(int'($urandom_range(0, int'(screen_h) + 40)) - 20);
                c.r     = RADIUS_BITS'(rad);
                send(c, 1'b0);
                repeat (n_ticks) begin
                    c     = random_cmd();
                    c.cmd = CMD_TICK;
                    send(c, 1'b0);
                end
            end else begin
                send(random_cmd(), 1'b0);
            end
        end
    endtask

    // Receiver: pop at random, never idle while calm
    always @(posedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each popped point with the oldest prediction
    always @(posedge i_clk) begin
        point_t want;
        string  bad;
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                if (fail_count < SHOWN_ERRORS)
                    $display("%0t: unexpected point x=%0d y=%0d fin=%0b last=%0b",
                             $realtime, o_pixel_x, o_pixel_y, o_finished, o_last);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                bad  = "";
                if (o_pixel_x     !== want.px)    bad = {bad, " pixel_x"};
                if (o_pixel_y     !== want.py)    bad = {bad, " pixel_y"};
                if (o_pixel_color !== want.color) bad = {bad, " pixel_color"};
                if (o_visible     !== want.vis)   bad = {bad, " visible"};
                if (o_finished    !== want.fin)   bad = {bad, " finished"};
                if (o_last        !== want.last)  bad = {bad, " last"};
                if (bad != "") begin
                    if (fail_count < SHOWN_ERRORS) begin
                        $write("%0t: point %0d wrong:%s exp x=%0d y=%0d c=%h v=%0b f=%0b l=%0b",
                               $realtime, points_popped, bad, want.px, want.py,
                               want.color, want.vis, want.fin, want.last);
                        $display(" got x=%0d y=%0d c=%h v=%0b f=%0b l=%0b",
                                 o_pixel_x, o_pixel_y, o_pixel_color, o_visible,
                                 o_finished, o_last);
                    end
                    fail_count++;
                end
                points_popped++;
            end
        end
    end

    // Watchdog: count cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Stalled for %0d cycles with %0d points outstanding",
                 STALL_LIMIT, pending_pixels.size());
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        // Opening table: reset state, wrap extremes, negative radius, edges
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b1});
        opening_rows.push_back('{'{CMD_START,  16'sd10,     16'sd20,    13'sd0,     16'hFFFF}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   -16'sd1,     -16'sd1,    -13'sd1,    16'hFFFF}, 1'b1});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b1});
        opening_rows.push_back('{'{CMD_START,  -16'sd32768, 16'sd32767, 13'sd4095,  16'h0000}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b0});
        opening_rows.push_back('{'{CMD_START,  16'sd32767,  -16'sd32768, -13'sd4096, 16'hAAAA}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b1});
        opening_rows.push_back('{'{CMD_START,  16'sd120,    16'sd160,   13'sd5,     16'h1234}, 1'b0});
        repeat (4)
            opening_rows.push_back('{'{CMD_TICK, 16'sd0,    16'sd0,     13'sd0,     16'h0000}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b1});
        opening_rows.push_back('{'{CMD_START,  16'sd0,      16'sd0,     13'sd3,     16'h5555}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b0});
        // Restart mid-circle on the screen's far corner
        opening_rows.push_back('{'{CMD_START,  16'sd239,    16'sd319,   13'sd1,     16'h8001}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b0});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b1});
        opening_rows.push_back('{'{CMD_TICK,   16'sd0,      16'sd0,     13'sd0,     16'h0000}, 1'b1});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[i]) send(opening_rows[i].c, opening_rows[i].ends_circle);

        // Random phases under different screens; the first without any idling
        settle();
        set_screen(SCREEN_BITS'(320), SCREEN_BITS'(320));
        calm = 1'b1;
        draw_random(80);
        settle();
        calm = 1'b0;
        set_screen(SCREEN_BITS'(1), SCREEN_BITS'(1));
        draw_random(80);
        settle();
        set_screen(SCREEN_BITS'(0), SCREEN_BITS'(320));
        draw_random(60);
        repeat (2) begin
            settle();
            set_screen(SCREEN_BITS'($urandom_range(1, 320)),
                       SCREEN_BITS'($urandom_range(1, 320)));
            draw_random(90);
        end
        settle();

        if (pending_pixels.size() != 0) begin
            $display("%0d predicted points never appeared", pending_pixels.size());
            fail_count++;
        end
        $display("Sent %0d commands (%0d ticks) over %0d screen sizes, incl. 0, 1 and 320",
                 items_sent, ticks_sent, settings_used);
        $display("Checked %0d outline points and finish markers, %0d failures",
                 points_popped, fail_count);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
